FILE: rtl/core/byte_fifo_with_urgent_mark_top_macros.svh
// Assertion macros for the byte FIFO with urgent mark.
`ifndef BYTE_FIFO_WITH_URGENT_MARK_TOP_MACROS_SVH
`define BYTE_FIFO_WITH_URGENT_MARK_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BFUM_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");
`define BFUM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define BFUM_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define BFUM_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

FILE: rtl/core/bfum_pkg.sv
package bfum_pkg;

  localparam int DEPTH_DEF = 4096;
  localparam int OP_W      = 3;
  localparam int DATA_W    = 8;

  localparam logic [OP_W-1:0] OP_PUSH       = 3'd0;
  localparam logic [OP_W-1:0] OP_POP        = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK       = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_MARK = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

FILE: rtl/core/byte_fifo_with_urgent_mark_top.sv
// Byte FIFO with one urgent mark, DEPTH bytes deep.
// Input: an operation (in_op: push, pop, mark last pushed, clear mark,
// query) and a byte (in_data_in, used by push) transfer at a clock edge
// with start high and busy low.
// Output: one result per operation, shown for exactly one cycle with
// out_valid high: popped byte, op_ok, free count, readable count up to a
// pending mark, at-mark flag and mark-pending flag. The receiver cannot
// stall; each result must be taken in its cycle.
// Sequence: the transfer edge captures the operation and reads the byte
// store; the EXEC state updates the FIFO and registers the result, which
// is shown in the REPLY state. Busy is high for one cycle after each
// transfer, set by the registered read of the byte store ahead of the
// state update. A new operation may transfer in the result cycle.
// Reset (rst_n low, synchronous) empties the FIFO and clears the mark;
// the byte store is not cleared, and no clearing pass runs after reset.
module byte_fifo_with_urgent_mark_top #(
  parameter int DEPTH = bfum_pkg::DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [bfum_pkg::OP_W-1:0]   in_op,
  input  logic [bfum_pkg::DATA_W-1:0] in_data_in,
  output logic                        out_valid,
  output logic [bfum_pkg::DATA_W-1:0] out_data_out,
  output logic                        out_op_ok,
  output logic [CNT_W-1:0]            out_free_count,
  output logic [CNT_W-1:0]            out_readable_count,
  output logic                        out_at_mark,
  output logic                        out_mark_pending
);

  bfum_pkg::cmd_t cmd;

  bfum_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bfum_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_op              (in_op),
    .in_data_in         (in_data_in),
    .out_data_out       (out_data_out),
    .out_op_ok          (out_op_ok),
    .out_free_count     (out_free_count),
    .out_readable_count (out_readable_count),
    .out_at_mark        (out_at_mark),
    .out_mark_pending   (out_mark_pending)
  );

endmodule

FILE: rtl/core/bfum_ctrl.sv
`include "byte_fifo_with_urgent_mark_top_macros.svh"

module bfum_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  output bfum_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_REPLY = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      ST_IDLE, ST_REPLY: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_REPLY;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r == ST_EXEC);
  assign out_valid = (state_r == ST_REPLY);

  `BFUM_ASSERT_NEXT(a_transfer_runs_exec, clk, rst_n, start && !busy, busy)
  `BFUM_ASSERT_NEXT(a_exec_then_reply, clk, rst_n, busy, out_valid && !busy)
  `BFUM_ASSERT_IMPLIES(a_reply_not_busy, clk, rst_n, out_valid, !busy)

endmodule

FILE: rtl/core/bfum_dp.sv
`include "byte_fifo_with_urgent_mark_top_macros.svh"

module bfum_dp #(
  parameter int DEPTH = bfum_pkg::DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfum_pkg::cmd_t              cmd,
  input  logic [bfum_pkg::OP_W-1:0]   in_op,
  input  logic [bfum_pkg::DATA_W-1:0] in_data_in,
  output logic [bfum_pkg::DATA_W-1:0] out_data_out,
  output logic                        out_op_ok,
  output logic [CNT_W-1:0]            out_free_count,
  output logic [CNT_W-1:0]            out_readable_count,
  output logic                        out_at_mark,
  output logic                        out_mark_pending
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [bfum_pkg::DATA_W-1:0] mem [DEPTH];

  logic [bfum_pkg::OP_W-1:0]   op_r;
  logic [bfum_pkg::DATA_W-1:0] din_r;
  logic [bfum_pkg::DATA_W-1:0] rdata_r;
  logic [bfum_pkg::DATA_W-1:0] dout_r, dout_nxt;
  logic                        ok_r, ok_nxt;
  logic [IDX_W-1:0]            wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]            rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]            mark_idx_r, mark_idx_nxt;
  logic                        mark_v_r, mark_v_nxt;
  logic [CNT_W-1:0]            fill_r, fill_nxt;
  logic                        mem_we;
  logic                        at_mark;
  logic [CNT_W-1:0]            mark_dist;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      din_r   <= in_data_in;
      rdata_r <= mem[rd_idx_r];
    end
    if (mem_we) begin
      mem[wr_idx_r] <= din_r;
    end
  end

  always_comb begin
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    mark_idx_nxt = mark_idx_r;
    mark_v_nxt   = mark_v_r;
    fill_nxt     = fill_r;
    dout_nxt     = dout_r;
    ok_nxt       = ok_r;
    mem_we       = 1'b0;
    if (cmd.exec) begin
      dout_nxt = '0;
      ok_nxt   = 1'b0;
      case (op_r)
        bfum_pkg::OP_PUSH: begin
          if (fill_r != CNT_FULL) begin
            mem_we     = 1'b1;
            wr_idx_nxt = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + IDX_W'(1);
            fill_nxt   = fill_r + CNT_W'(1);
            ok_nxt     = 1'b1;
          end
        end
        bfum_pkg::OP_POP: begin
          if (fill_r != '0) begin
            dout_nxt = rdata_r;
            if (mark_v_r && (mark_idx_r == rd_idx_r)) begin
              mark_v_nxt = 1'b0;
            end
            rd_idx_nxt = (rd_idx_r == IDX_LAST) ? '0 : rd_idx_r + IDX_W'(1);
            fill_nxt   = fill_r - CNT_W'(1);
            ok_nxt     = 1'b1;
          end
        end
        bfum_pkg::OP_MARK: begin
          if (fill_r != '0) begin
            mark_idx_nxt = (wr_idx_r == '0) ? IDX_LAST : wr_idx_r - IDX_W'(1);
            mark_v_nxt   = 1'b1;
            ok_nxt       = 1'b1;
          end
        end
        bfum_pkg::OP_CLEAR_MARK: begin
          mark_v_nxt = 1'b0;
          ok_nxt     = 1'b1;
        end
        bfum_pkg::OP_QUERY: begin
          ok_nxt = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      mark_idx_r <= '0;
      mark_v_r   <= 1'b0;
      fill_r     <= '0;
    end else begin
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      mark_idx_r <= mark_idx_nxt;
      mark_v_r   <= mark_v_nxt;
      fill_r     <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dout_r <= dout_nxt;
    ok_r   <= ok_nxt;
  end

  // distance wraps modulo DEPTH
  assign at_mark   = mark_v_r && (mark_idx_r == rd_idx_r);
  assign mark_dist = CNT_W'(mark_idx_r) - CNT_W'(rd_idx_r)
                   + ((mark_idx_r < rd_idx_r) ? CNT_FULL : CNT_W'(0));

  assign out_data_out       = dout_r;
  assign out_op_ok          = ok_r;
  assign out_free_count     = CNT_FULL - fill_r;
  assign out_readable_count = (!mark_v_r || at_mark) ? fill_r : mark_dist;
  assign out_at_mark        = at_mark;
  assign out_mark_pending   = mark_v_r;

  `BFUM_ASSERT_IMPLIES(a_fill_in_range, clk, rst_n, 1'b1, fill_r <= CNT_FULL)
  `BFUM_ASSERT_IMPLIES(a_mark_needs_data, clk, rst_n, mark_v_r, fill_r != '0)
  `BFUM_ASSERT_IMPLIES(a_empty_aligned, clk, rst_n, fill_r == '0, rd_idx_r == wr_idx_r)
  `BFUM_ASSERT_IMPLIES(a_full_aligned, clk, rst_n, fill_r == CNT_FULL, rd_idx_r == wr_idx_r)

endmodule
